// ===== sv/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes, widths and the payload that travels along the divider chain.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int DATA_W        = 32;
  localparam int PROD_W        = 64;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_CMP      = 4'd4,
    OP_MIN      = 4'd5,
    OP_MAX      = 4'd6,
    OP_INC      = 4'd7,
    OP_DEC      = 4'd8,
    OP_TO_INT   = 4'd9,
    OP_FROM_INT = 4'd10
  } op_t;

  typedef struct packed {
    logic [3:0]        op;
    logic [DATA_W-1:0] res;
    logic              gt;
    logic              lt;
    logic              eq;
    logic              ovf;
    logic              dz;
    logic              a_pos;
    logic              a_neg;
    logic              q_neg;
    logic [PROD_W-1:0] prod;
  } pay_t;

endpackage

// ===== sv/fpa_cell.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU divider cell
// One restoring division step per cell; the transaction payload rides along.
// ----------------------------------------------------------------------------
module fpa_cell #(
  parameter int NQ = 40
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  fpa_pkg::pay_t             in_pay,
  input  logic [fpa_pkg::DATA_W-1:0] in_den,
  input  logic [fpa_pkg::DATA_W-1:0] in_rem,
  input  logic [NQ-1:0]             in_qn,
  output logic                      out_valid,
  output fpa_pkg::pay_t             out_pay,
  output logic [fpa_pkg::DATA_W-1:0] out_den,
  output logic [fpa_pkg::DATA_W-1:0] out_rem,
  output logic [NQ-1:0]             out_qn
);

  logic                       valid_r;
  fpa_pkg::pay_t              pay_r;
  logic [fpa_pkg::DATA_W-1:0] den_r;
  logic [fpa_pkg::DATA_W-1:0] rem_r;
  logic [fpa_pkg::DATA_W-1:0] rem_nxt;
  logic [NQ-1:0]              qn_r;
  logic [NQ-1:0]              qn_nxt;
  logic [fpa_pkg::DATA_W:0]   shifted;
  logic [fpa_pkg::DATA_W:0]   diff;

  always_comb begin
    shifted = {in_rem, in_qn[NQ-1]};
    diff    = shifted - {1'b0, in_den};
    if (shifted >= {1'b0, in_den}) begin
      rem_nxt = diff[fpa_pkg::DATA_W-1:0];
      qn_nxt  = {in_qn[NQ-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[fpa_pkg::DATA_W-1:0];
      qn_nxt  = {in_qn[NQ-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    pay_r <= in_pay;
    den_r <= in_den;
    rem_r <= rem_nxt;
    qn_r  <= qn_nxt;
  end

  assign out_valid = valid_r;
  assign out_pay   = pay_r;
  assign out_den   = den_r;
  assign out_rem   = rem_r;
  assign out_qn    = qn_r;

endmodule

// ===== sv/fixed_point_alu_q24_8_top.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU, Q24.8 by default
// Saturating signed fixed-point arithmetic with round-half-away division.
// ----------------------------------------------------------------------------
// A transaction is taken in every cycle that start is high; busy stays low.
// Every result appears with out_valid after an input register and the chain of
// divider cells, one cell per quotient bit, that every transaction passes
// through, and an output register. Results arrive in order and must be
// captured in the cycle they are shown.
module fixed_point_alu_q24_8_top #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_op,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic        out_valid,
  output logic signed [31:0] out_result,
  output logic        out_greater,
  output logic        out_less,
  output logic        out_equal,
  output logic        out_overflow,
  output logic        out_divide_by_zero
);

  localparam int NQ = fpa_pkg::DATA_W + FRAC_BITS;
  localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;
  localparam logic [31:0] RMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] RMIN = 32'h8000_0000;

  function automatic logic [32:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic        ovf;
    logic [31:0] res;
    if (!neg) begin
      ovf = |mag[63:31];
      res = ovf ? RMAX : mag[31:0];
    end else begin
      ovf = (mag > 64'h8000_0000);
      res = ovf ? RMIN : (32'd0 - mag[31:0]);
    end
    return {ovf, res};
  endfunction

  function automatic logic [32:0] sat33(input logic [32:0] s);
    if (s[32] != s[31]) begin
      return {1'b1, (s[32] ? RMIN : RMAX)};
    end
    return {1'b0, s[31:0]};
  endfunction

  logic          accept;
  fpa_pkg::pay_t pay_nxt;
  logic [31:0]   mag_a;
  logic [31:0]   mag_b;
  logic [32:0]   sa;
  logic [32:0]   sb;
  logic [32:0]   tmp;
  logic signed [63:0] ext;

  logic                        v_w   [0:NQ];
  fpa_pkg::pay_t               pay_w [0:NQ];
  logic [fpa_pkg::DATA_W-1:0]  den_w [0:NQ];
  logic [fpa_pkg::DATA_W-1:0]  rem_w [0:NQ];
  logic [NQ-1:0]               qn_w  [0:NQ];

  logic          v0_r;
  fpa_pkg::pay_t pay0_r;
  logic [31:0]   den0_r;
  logic [NQ-1:0] qn0_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    mag_a = in_operand_a[31] ? (32'd0 - in_operand_a) : in_operand_a;
    mag_b = in_operand_b[31] ? (32'd0 - in_operand_b) : in_operand_b;
    sa    = {in_operand_a[31], in_operand_a};
    sb    = {in_operand_b[31], in_operand_b};
    ext   = 64'(in_operand_a) <<< FRAC_BITS;
    tmp   = 33'd0;
    pay_nxt       = '0;
    pay_nxt.op    = in_op;
    pay_nxt.a_pos = !in_operand_a[31] && (in_operand_a != 32'sd0);
    pay_nxt.a_neg = in_operand_a[31];
    pay_nxt.q_neg = in_operand_a[31] != in_operand_b[31];
    pay_nxt.prod  = 64'(in_operand_a * 64'(in_operand_b));
    case (in_op)
      fpa_pkg::OP_ADD: begin
        tmp = sat33(sa + sb);
        {pay_nxt.ovf, pay_nxt.res} = tmp;
      end
      fpa_pkg::OP_SUB: begin
        tmp = sat33(sa - sb);
        {pay_nxt.ovf, pay_nxt.res} = tmp;
      end
      fpa_pkg::OP_INC: begin
        tmp = sat33(sa + 33'd1);
        {pay_nxt.ovf, pay_nxt.res} = tmp;
      end
      fpa_pkg::OP_DEC: begin
        tmp = sat33(sa - 33'd1);
        {pay_nxt.ovf, pay_nxt.res} = tmp;
      end
      fpa_pkg::OP_CMP: begin
        pay_nxt.gt = in_operand_a > in_operand_b;
        pay_nxt.lt = in_operand_a < in_operand_b;
        pay_nxt.eq = in_operand_a == in_operand_b;
      end
      fpa_pkg::OP_MIN: pay_nxt.res = (in_operand_a < in_operand_b) ? in_operand_a : in_operand_b;
      fpa_pkg::OP_MAX: pay_nxt.res = (in_operand_a > in_operand_b) ? in_operand_a : in_operand_b;
      fpa_pkg::OP_TO_INT: pay_nxt.res = 32'(in_operand_a >>> FRAC_BITS);
      fpa_pkg::OP_FROM_INT: begin
        if (ext > 64'sh7FFF_FFFF) begin
          pay_nxt.ovf = 1'b1;
          pay_nxt.res = RMAX;
        end else if (ext < -64'sh8000_0000) begin
          pay_nxt.ovf = 1'b1;
          pay_nxt.res = RMIN;
        end else begin
          pay_nxt.res = ext[31:0];
        end
      end
      fpa_pkg::OP_DIV: pay_nxt.dz = (in_operand_b == 32'sd0);
      default: pay_nxt.res = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    pay0_r <= pay_nxt;
    den0_r <= mag_b;
    qn0_r  <= NQ'(mag_a) << FRAC_BITS;
  end

  assign v_w[0]   = v0_r;
  assign pay_w[0] = pay0_r;
  assign den_w[0] = den0_r;
  assign rem_w[0] = '0;
  assign qn_w[0]  = qn0_r;

  for (genvar i = 0; i < NQ; i++) begin : g_cell
    fpa_cell #(.NQ(NQ)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_w[i]),
      .in_pay    (pay_w[i]),
      .in_den    (den_w[i]),
      .in_rem    (rem_w[i]),
      .in_qn     (qn_w[i]),
      .out_valid (v_w[i+1]),
      .out_pay   (pay_w[i+1]),
      .out_den   (den_w[i+1]),
      .out_rem   (rem_w[i+1]),
      .out_qn    (qn_w[i+1])
    );
  end

  fpa_pkg::pay_t pt;
  logic [63:0]   pmag;
  logic [63:0]   qm;
  logic [NQ:0]   qr;
  logic          up;
  logic [32:0]   fin;
  logic          valid_r;
  logic [31:0]   result_r;
  logic          gt_r;
  logic          lt_r;
  logic          eq_r;
  logic          ovf_r;
  logic          dz_r;

  always_comb begin
    pt   = pay_w[NQ];
    pmag = pt.prod[63] ? (64'd0 - pt.prod) : pt.prod;
    qm   = (pmag + HALF) >> FRAC_BITS;
    up   = {rem_w[NQ], 1'b0} >= {1'b0, den_w[NQ]};
    qr   = {1'b0, qn_w[NQ]} + (NQ+1)'(up);
    fin  = {pt.ovf, pt.res};
    case (pt.op)
      fpa_pkg::OP_MUL: fin = sat_mag(qm, pt.prod[63]);
      fpa_pkg::OP_DIV: begin
        if (pt.dz) begin
          fin = {1'b0, (pt.a_pos ? RMAX : (pt.a_neg ? RMIN : 32'd0))};
        end else begin
          fin = sat_mag(64'(qr), pt.q_neg);
        end
      end
      default: fin = {pt.ovf, pt.res};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v_w[NQ];
    end
    {ovf_r, result_r} <= fin;
    gt_r <= pt.gt;
    lt_r <= pt.lt;
    eq_r <= pt.eq;
    dz_r <= pt.dz;
  end

  assign out_valid          = valid_r;
  assign out_result         = result_r;
  assign out_greater        = gt_r;
  assign out_less           = lt_r;
  assign out_equal          = eq_r;
  assign out_overflow       = ovf_r;
  assign out_divide_by_zero = dz_r;

endmodule

// ===== tb/tb_fixed_point_alu_q24_8_top.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed and random transactions into the Q24.8 ALU with random gaps;
// checks every result against a table or an exact integer predictor.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_q24_8_top;

  localparam int FRAC    = fpa_pkg::FRAC_BITS_DEF;
  localparam int LAT     = FRAC + 34;
  localparam int N_RAND  = 1450;
  localparam int LIMIT   = 400000;
  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] result;
    logic               greater;
    logic               less;
    logic               equal;
    logic               overflow;
    logic               dz;
  } alu_res_t;

  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               known;
    alu_res_t           res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_op = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic out_valid;
  logic signed [31:0] out_result;
  logic out_greater, out_less, out_equal, out_overflow, out_divide_by_zero;

  alu_res_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  fixed_point_alu_q24_8_top #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_result(out_result), .out_greater(out_greater),
    .out_less(out_less), .out_equal(out_equal), .out_overflow(out_overflow),
    .out_divide_by_zero(out_divide_by_zero)
  );

  always #5 clk = ~clk;

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v,
                                                inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic alu_res_t alu_predict(input logic [3:0] op,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_res_t r;
    logic signed [63:0] sa, sb, v;
    logic [63:0] mag, num, den, q, rem;
    logic neg, ovf;
    r = '0;
    sa = a;
    sb = b;
    v = 0;
    ovf = 1'b0;
    case (op)
      fpa_pkg::OP_ADD: v = sat32(sa + sb, ovf);
      fpa_pkg::OP_SUB: v = sat32(sa - sb, ovf);
      fpa_pkg::OP_MUL: begin
        v = sa * sb;
        neg = v < 0;
        mag = neg ? -v : v;
        q = (FRAC > 0) ? ((mag + (64'd1 << (FRAC - 1))) >> FRAC) : mag;
        v = sat32(neg ? -$signed(q) : $signed(q), ovf);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
          v = (sa > 0) ? 64'sd2147483647 : (sa < 0) ? -64'sd2147483648 : 0;
        end else begin
          neg = (sa < 0) != (sb < 0);
          num = (sa < 0 ? -sa : sa) << FRAC;
          den = sb < 0 ? -sb : sb;
          q = num / den;
          rem = num % den;
          if (rem >= den - rem) q = q + 1;
          v = sat32(neg ? -$signed(q) : $signed(q), ovf);
        end
      end
      fpa_pkg::OP_CMP: begin
        r.greater = sa > sb;
        r.less = sa < sb;
        r.equal = sa == sb;
      end
      fpa_pkg::OP_MIN: v = (sa < sb) ? sa : sb;
      fpa_pkg::OP_MAX: v = (sa > sb) ? sa : sb;
      fpa_pkg::OP_INC: v = sat32(sa + 1, ovf);
      fpa_pkg::OP_DEC: v = sat32(sa - 1, ovf);
      fpa_pkg::OP_TO_INT: v = sa >>> FRAC;
      fpa_pkg::OP_FROM_INT: v = sat32(sa * (64'sd1 <<< FRAC), ovf);
      default: v = 0;
    endcase
    r.result = v[31:0];
    r.overflow = ovf;
    return r;
  endfunction

  task automatic send(input logic [3:0] op, input logic signed [31:0] a,
                      input logic signed [31:0] b, input logic known,
                      input alu_res_t res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_op <= 4'($urandom);
      in_operand_a <= $urandom;
      in_operand_b <= $urandom;
      @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(known ? res : alu_predict(op, a, b));
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? SMAX - $urandom_range(3) : SMIN + $urandom_range(3);
      1: return $signed($urandom_range(2047)) - 1024;
      2: return $signed($urandom_range(131071)) - 65536;
      3: return $signed($urandom) >>> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    alu_res_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_result !== e.result) begin
          $error("result: expected %0d, got %0d", e.result, out_result);
          errors++;
        end
        if (out_greater !== e.greater) begin
          $error("greater: expected %0b, got %0b", e.greater, out_greater);
          errors++;
        end
        if (out_less !== e.less) begin
          $error("less: expected %0b, got %0b", e.less, out_less);
          errors++;
        end
        if (out_equal !== e.equal) begin
          $error("equal: expected %0b, got %0b", e.equal, out_equal);
          errors++;
        end
        if (out_overflow !== e.overflow) begin
          $error("overflow: expected %0b, got %0b", e.overflow, out_overflow);
          errors++;
        end
        if (out_divide_by_zero !== e.dz) begin
          $error("divide_by_zero: expected %0b, got %0b", e.dz, out_divide_by_zero);
          errors++;
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("tb_fixed_point_alu_q24_8_top failed");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    int n;
    logic [3:0] op;
    rows = '{
      '{fpa_pkg::OP_ADD,      SMAX,   32'sd1,  1, '{SMAX, 0, 0, 0, 1, 0}},
      '{fpa_pkg::OP_ADD,      SMIN,   -32'sd1, 1, '{SMIN, 0, 0, 0, 1, 0}},
      '{fpa_pkg::OP_SUB,      SMIN,   32'sd1,  1, '{SMIN, 0, 0, 0, 1, 0}},
      '{fpa_pkg::OP_SUB,      SMAX,   SMIN,    1, '{SMAX, 0, 0, 0, 1, 0}},
      '{fpa_pkg::OP_MUL,      32'sd384, -32'sd640, 0, '0},
      '{fpa_pkg::OP_MUL,      SMAX,   SMAX,    1, '{SMAX, 0, 0, 0, 1, 0}},
      '{fpa_pkg::OP_MUL,      SMIN,   SMIN,    1, '{SMAX, 0, 0, 0, 1, 0}},
      '{fpa_pkg::OP_MUL,      32'sd1, 32'sd128, 0, '0},
      '{fpa_pkg::OP_DIV,      32'sd5, 32'sd0,  1, '{SMAX, 0, 0, 0, 0, 1}},
      '{fpa_pkg::OP_DIV,      -32'sd5, 32'sd0, 1, '{SMIN, 0, 0, 0, 0, 1}},
      '{fpa_pkg::OP_DIV,      32'sd0, 32'sd0,  1, '{32'sd0, 0, 0, 0, 0, 1}},
      '{fpa_pkg::OP_DIV,      SMIN,   -32'sd1, 1, '{SMAX, 0, 0, 0, 1, 0}},
      '{fpa_pkg::OP_DIV,      -32'sd768, 32'sd512, 0, '0},
      '{fpa_pkg::OP_CMP,      SMAX,   SMIN,    1, '{32'sd0, 1, 0, 0, 0, 0}},
      '{fpa_pkg::OP_CMP,      SMIN,   SMAX,    1, '{32'sd0, 0, 1, 0, 0, 0}},
      '{fpa_pkg::OP_CMP,      32'sd7, 32'sd7,  1, '{32'sd0, 0, 0, 1, 0, 0}},
      '{fpa_pkg::OP_MIN,      SMIN,   SMAX,    1, '{SMIN, 0, 0, 0, 0, 0}},
      '{fpa_pkg::OP_MAX,      SMIN,   SMAX,    1, '{SMAX, 0, 0, 0, 0, 0}},
      '{fpa_pkg::OP_INC,      SMAX,   32'sd0,  1, '{SMAX, 0, 0, 0, 1, 0}},
      '{fpa_pkg::OP_DEC,      SMIN,   32'sd0,  1, '{SMIN, 0, 0, 0, 1, 0}},
      '{fpa_pkg::OP_TO_INT,   -32'sd1, 32'sd0, 1, '{-32'sd1, 0, 0, 0, 0, 0}},
      '{fpa_pkg::OP_TO_INT,   SMIN,   SMAX,    0, '0},
      '{fpa_pkg::OP_FROM_INT, SMAX,   32'sd0,  1, '{SMAX, 0, 0, 0, 1, 0}},
      '{fpa_pkg::OP_FROM_INT, -32'sd3, 32'sd0, 0, '0},
      '{4'd15,                SMAX,   SMIN,    1, '0}
    };
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send(rows[i].op, rows[i].a, rows[i].b, rows[i].known, rows[i].res);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 0) ? 0 : (phase == 1) ? 67 : (phase == 2) ? 0 : 37;
      n = N_RAND / 4;
      for (int k = 0; k < n; k++) begin
        op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
        if (op == fpa_pkg::OP_DIV && $urandom_range(9) == 0)
          send(op, rand_operand(), 32'sd0, 0, '0);
        else if (op == fpa_pkg::OP_CMP && $urandom_range(3) == 0)
          send(op, k, k, 0, '0);
        else
          send(op, rand_operand(), rand_operand(), 0, '0);
      end
    end
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0)
      $display("tb_fixed_point_alu_q24_8_top passed");
    else
      $display("tb_fixed_point_alu_q24_8_top failed");
    $finish;
  end

endmodule
